// ===== rtl/core/wfba_pkg.sv =====
`default_nettype none
package wfba_pkg;

    // defaults for the top-level parameters
    localparam int MAX_BLOCKS_DEF = 32;
    localparam int SIZE_BITS_DEF  = 16;

    // fixed field widths
    localparam int KIND_W  = 1;
    localparam int INDEX_W = 5;
    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 6;

    // config port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_BLOCK_COUNT = 1'b0;   // register index, paddr[2]

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] block_index;
        logic [SIZE_W-1:0]  size_value;
    } t_in_item;

    typedef struct packed {
        logic               granted;
        logic [INDEX_W-1:0] chosen_block;
        logic [SIZE_W-1:0]  leftover;
    } t_out_item;

endpackage
`default_nettype wire

// ===== rtl/core/wfba_ram.sv =====
`default_nettype none
module wfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [AW-1:0]            i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/worst_fit_block_allocator.sv =====
`default_nettype none
// Worst-fit block allocator.
//
// Input channel (i_in_valid / o_in_ready, payload i_in) takes two kinds of item.
// A load item writes one block size into the table and frees that block; it
// completes in the cycle it is accepted and gives no result. A request item
// starts a scan over the free blocks below block_count; the block with the
// largest size (lowest index on ties) that still holds the request is marked
// allocated. Each request gives exactly one result on the output channel
// (o_out_valid / i_out_ready, payload o_out); a failed request returns all zero.
// A request scans N entries, N = block_count capped at the table depth, one
// entry per cycle through the single size comparator; o_in_ready is low
// meanwhile, so the input is held until the result is registered.
// Loads need no scan, so they may stream back to back.
// If the receiver stalls, the held result stays in the output register; the
// next item is still accepted, and a further request waits at its end until
// the output register is free.
// Reset (synchronous, active low) clears block_count and all allocation marks;
// the size table is not cleared, so load every block in use before requesting.
// block_count is written through the APB port at byte address 0 (pready is
// always high); write it only while no request is in flight.
module worst_fit_block_allocator #(
    parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = wfba_pkg::SIZE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item input
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire wfba_pkg::t_in_item            i_in,
    // result output
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output wfba_pkg::t_out_item                o_out,
    // APB config
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [wfba_pkg::APB_AW-1:0]   paddr,
    input  wire logic [wfba_pkg::APB_DW-1:0]   pwdata,
    output logic      [wfba_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);
    // table index width
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    // counter/limit width: holds MAX_BLOCKS and the 6-bit count
    localparam int LIM_W0 = $clog2(MAX_BLOCKS + 1);
    localparam int LIM_W  = (LIM_W0 > wfba_pkg::COUNT_W) ? LIM_W0 : wfba_pkg::COUNT_W;
    // widths for index / size conversion between fields and storage
    localparam int XI_W = (IDX_W > wfba_pkg::INDEX_W) ? IDX_W : wfba_pkg::INDEX_W;
    localparam int XS_W = (SIZE_BITS > wfba_pkg::SIZE_W) ? SIZE_BITS : wfba_pkg::SIZE_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [wfba_pkg::COUNT_W-1:0] r_block_count;
    logic [MAX_BLOCKS-1:0]        r_marks;
    logic [LIM_W-1:0]             r_limit, r_rd_idx;
    logic                         r_cmp_vld;
    logic [IDX_W-1:0]             r_cmp_idx;
    logic [SIZE_BITS-1:0]         r_req;
    logic                         r_found;
    logic [IDX_W-1:0]             r_best_idx;
    logic [SIZE_BITS-1:0]         r_best_size;
    logic                         r_out_valid;
    wfba_pkg::t_out_item          r_out;

    logic                         w_in_acc, w_load, w_req, w_load_ok;
    logic                         w_cfg_wr, w_issue, w_fin_go, w_better;
    logic [XI_W-1:0]              w_idx_ext;
    logic [IDX_W-1:0]             w_load_idx;
    logic [XS_W-1:0]              w_size_ext;
    logic [SIZE_BITS-1:0]         w_size;
    logic [LIM_W-1:0]             w_cnt_ext, w_lim;
    logic [SIZE_BITS-1:0]         w_rdata;
    logic [SIZE_BITS-1:0]         w_left;
    logic [XS_W-1:0]              w_left_ext;
    logic [XI_W-1:0]              w_best_ext;

    // ---------------- handshakes and decode ----------------
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_load     = w_in_acc && (i_in.kind == wfba_pkg::KIND_LOAD);
    assign w_req      = w_in_acc && (i_in.kind == wfba_pkg::KIND_REQUEST);

    // field <-> storage width conversion
    assign w_idx_ext  = XI_W'(i_in.block_index);
    assign w_load_idx = w_idx_ext[IDX_W-1:0];
    assign w_load_ok  = (LIM_W'(i_in.block_index) < LIM_W'(MAX_BLOCKS));
    assign w_size_ext = XS_W'(i_in.size_value);
    assign w_size     = w_size_ext[SIZE_BITS-1:0];

    // scan limit: count saturates at the table depth
    assign w_cnt_ext = LIM_W'(r_block_count);
    assign w_lim     = (w_cnt_ext > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : w_cnt_ext;

    // ---------------- config port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == wfba_pkg::REG_BLOCK_COUNT);
    assign prdata   = (paddr[2] == wfba_pkg::REG_BLOCK_COUNT)
                      ? wfba_pkg::APB_DW'(r_block_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= '0;
        end else if (w_cfg_wr) begin
            r_block_count <= pwdata[wfba_pkg::COUNT_W-1:0];
        end
    end

    // ---------------- size table ----------------
    wfba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_sizes (
        .i_clk   (i_clk),
        .i_we    (w_load && w_load_ok),
        .i_waddr (w_load_idx),
        .i_wdata (w_size),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // ---------------- scan datapath ----------------
    // issue one read per cycle; the comparator sees it in the next cycle
    assign w_issue = (r_state == ST_SCAN) && (r_rd_idx < r_limit);

    // leftover is monotonic in block size, so keep the largest size seen
    assign w_better = r_cmp_vld && !r_marks[r_cmp_idx] && (w_rdata >= r_req)
                      && (!r_found || (w_rdata > r_best_size));

    assign w_fin_go = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    assign w_left     = r_best_size - r_req;
    assign w_left_ext = XS_W'(w_left);
    assign w_best_ext = XI_W'(r_best_idx);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_req) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // last compare commits at this edge
                if (r_rd_idx == r_limit) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            r_marks     <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= w_issue;
            if (w_load && w_load_ok) begin
                r_marks[w_load_idx] <= 1'b0;
            end
            if (w_fin_go && r_found) begin
                r_marks[r_best_idx] <= 1'b1;
            end
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_req) begin
            r_req    <= w_size;
            r_limit  <= w_lim;
            r_rd_idx <= '0;
        end else if (w_issue) begin
            r_rd_idx <= r_rd_idx + LIM_W'(1);
        end
        r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        if (w_req) begin
            r_found <= 1'b0;
        end else if (w_better) begin
            r_found     <= 1'b1;
            r_best_idx  <= r_cmp_idx;
            r_best_size <= w_rdata;
        end
        if (w_fin_go) begin
            r_out.granted      <= r_found;
            r_out.chosen_block <= r_found ? w_best_ext[wfba_pkg::INDEX_W-1:0] : '0;
            r_out.leftover     <= r_found ? w_left_ext[wfba_pkg::SIZE_W-1:0] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------- assertions ----------------
    a_grant_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_go && r_found) |=> r_marks[$past(r_best_idx)])
        else $error("granted block not marked allocated");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.granted) |-> (o_out.chosen_block == '0 && o_out.leftover == '0))
        else $error("failed request carries non-zero fields");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_rd_idx <= r_limit))
        else $error("scan index past limit");

    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == ST_SCAN))
        else $error("compare outside scan");

    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_go |=> o_out_valid)
        else $error("finished request left no result");

endmodule
`default_nettype wire
